// File: rtl/core/interpolated_wavetable_reader_macros.svh
// Assertion macros for the checker of the interpolated wavetable reader.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef INTERPOLATED_WAVETABLE_READER_MACROS_SVH
`define INTERPOLATED_WAVETABLE_READER_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define IWR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked only outside reset.
`define IWR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define IWR_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/iwr_pkg.sv
// Package of the interpolated wavetable reader: widths, codes and shared types.
// Used by the top level, the interpolator and the checker; depends on nothing.
package iwr_pkg;

   // Defaults for the top-level parameters.
   localparam int TABLE_BITS_DEFAULT = 11;
   localparam int OCTAVES_DEFAULT    = 6;

   // Fixed field widths.
   localparam int PHASE_W     = 32;
   localparam int SAMPLE_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int INDEX_W     = 11;
   localparam int OCT_IDX_W   = 4;
   localparam int WAVE_W      = 2;
   localparam int OCT_CLAMP_W = 3;

   // Input tdata layout, lowest bit first.
   localparam int REQ_FIELDS_W = WAVE_W + OCT_IDX_W + PHASE_W + INDEX_W + SAMPLE_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int WAVE_LSB     = 0;
   localparam int OCT_LSB      = WAVE_LSB + WAVE_W;
   localparam int PHASE_LSB    = OCT_LSB + OCT_IDX_W;
   localparam int INDEX_LSB    = PHASE_LSB + PHASE_W;
   localparam int VALUE_LSB    = INDEX_LSB + INDEX_W;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } opcode_type;

   typedef enum logic [WAVE_W-1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_SAW      = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_TRIANGLE = 2'd3
   } wave_type;

   // A read item leaving the table stage for the interpolator.
   typedef struct packed {
      logic              valid;
      logic [FRAC_W-1:0] frac;
   } lerp_req_type;

endpackage

// File: rtl/core/interpolated_wavetable_reader.sv
// Interpolated wavetable reader. One item per clock is accepted while the output path moves;
// a read item's sample reaches rsp through the registered table read, then the multiply stage,
// then the add into the output register (table read at the accepting edge), and a write item
// produces no result. Both neighboring entries come from one table memory with two read ports
// and one write port, which sets the rate of one item a cycle.
// Table contents are undefined after reset: load each entry before reading it. There is no
// clearing pass. A read accepted in a later cycle than a write sees the written value.
module interpolated_wavetable_reader
   import iwr_pkg::*;
#(
   parameter int TABLE_BITS = TABLE_BITS_DEFAULT,
   parameter int OCTAVES    = OCTAVES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0: waveform, octave_index, phase, entry_index, entry_value, zero fill.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: opcode.
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: sample.
   output logic [SAMPLE_W-1:0]    rsp_tdata
);

   localparam int TABLE_COUNT = 1 + 3 * OCTAVES;
   localparam int TNUM_W      = $clog2(TABLE_COUNT);
   localparam int STORE_DEPTH = TABLE_COUNT << TABLE_BITS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   wave_type                   wave;
   logic signed [OCT_IDX_W-1:0] oct;
   logic [PHASE_W-1:0]         phase;
   logic [INDEX_W-1:0]         entry_index;
   logic [SAMPLE_W-1:0]        entry_value;
   logic [OCT_CLAMP_W-1:0]     oct_clamped;
   logic [WAVE_W-1:0]          wave_m1;
   logic [TNUM_W-1:0]          tnum;
   logic [TABLE_BITS-1:0]      idx0;
   logic [TABLE_BITS-1:0]      idx1;
   logic [TABLE_BITS-1:0]      wr_idx;
   logic                       accept;
   logic                       wr_en;
   logic                       lerp_ready;
   logic [SAMPLE_W-1:0]        rd_data_a;
   logic [SAMPLE_W-1:0]        rd_data_b;
   lerp_req_type               lerp_req_ff;
   lerp_req_type               lerp_req_in;

   // Unpack the item.
   assign wave        = wave_type'(req_tdata[WAVE_LSB +: WAVE_W]);
   assign oct         = req_tdata[OCT_LSB +: OCT_IDX_W];
   assign phase       = req_tdata[PHASE_LSB +: PHASE_W];
   assign entry_index = req_tdata[INDEX_LSB +: INDEX_W];
   assign entry_value = req_tdata[VALUE_LSB +: SAMPLE_W];

   // Table number: sine is table 0, then saw, square and triangle per octave.
   always_comb begin
      if (oct < 0) begin
         oct_clamped = '0;
      end else if (oct > (OCTAVES - 1)) begin
         oct_clamped = OCT_CLAMP_W'(OCTAVES - 1);
      end else begin
         oct_clamped = OCT_CLAMP_W'(oct);
      end
      wave_m1 = wave - WAVE_W'(1);
      if (wave == WAVE_SINE) begin
         tnum = '0;
      end else begin
         tnum = TNUM_W'(1) + TNUM_W'(wave_m1) * TNUM_W'(OCTAVES) + TNUM_W'(oct_clamped);
      end
   end

   // Entry positions: the top phase bits and the next entry with wrap, or the write index.
   assign idx0   = phase[PHASE_W-1 -: TABLE_BITS];
   assign idx1   = idx0 + TABLE_BITS'(1);
   assign wr_idx = TABLE_BITS'(entry_index);

   // Handshake: the table stage moves when empty or when the interpolator takes its item.
   assign req_tready = !lerp_req_ff.valid || lerp_ready;
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (opcode_type'(req_tuser) == OP_WRITE);

   // Table stage: a read item waits here alongside the registered memory data.
   always_comb begin
      lerp_req_in = lerp_req_ff;
      if (req_tready) begin
         lerp_req_in.valid = accept && (opcode_type'(req_tuser) == OP_READ);
         lerp_req_in.frac  = phase[PHASE_W-TABLE_BITS-FRAC_W +: FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lerp_req_ff.valid <= 1'b0;
      end else begin
         lerp_req_ff.valid <= lerp_req_in.valid;
      end
      lerp_req_ff.frac <= lerp_req_in.frac;
   end

   // Table memory: writes store one entry, reads fetch both neighbors at once.
   iwr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (ADDR_W'({tnum, wr_idx})),
      .wr_data   (entry_value),
      .rd_en     (req_tready),
      .rd_addr_a (ADDR_W'({tnum, idx0})),
      .rd_addr_b (ADDR_W'({tnum, idx1})),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Interpolation and output register.
   iwr_lerp u_lerp (
      .clock      (clock),
      .reset      (reset),
      .lerp_req   (lerp_req_ff),
      .s0         ($signed(rd_data_a)),
      .s1         ($signed(rd_data_b)),
      .lerp_ready (lerp_ready),
      .out_valid  (rsp_tvalid),
      .out_sample (rsp_tdata),
      .out_ready  (rsp_tready)
   );

endmodule

// File: rtl/core/iwr_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Stands alone; no package needed.
module iwr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read ports; the data registers hold while rd_en is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/core/iwr_lerp.sv
// Interpolation pipeline: multiply stage, then add stage into the output register.
// Depends on iwr_pkg.
module iwr_lerp
   import iwr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  lerp_req_type               lerp_req,
   input  logic signed [SAMPLE_W-1:0] s0,
   input  logic signed [SAMPLE_W-1:0] s1,
   output logic                       lerp_ready,
   output logic                       out_valid,
   output logic [SAMPLE_W-1:0]        out_sample,
   input  logic                       out_ready
);

   logic                       mul_valid_ff;
   logic                       mul_valid_in;
   logic signed [SAMPLE_W-1:0] s0_ff;
   logic [SAMPLE_W-1:0]        step_ff;
   logic [SAMPLE_W-1:0]        step_in;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [SAMPLE_W-1:0]        out_sample_ff;
   logic                       out_adv;
   logic                       mul_adv;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [2*SAMPLE_W+1:0] prod;

   // Stage enables: the output register frees when taken, the multiply stage when it moves on.
   assign out_adv    = !out_valid_ff || out_ready;
   assign mul_adv    = !mul_valid_ff || out_adv;
   assign lerp_ready = mul_adv;

   // frac * (s1 - s0), floored by 2^16; only the low sample bits survive the final add.
   always_comb begin
      diff    = (SAMPLE_W+1)'(s1) - (SAMPLE_W+1)'(s0);
      prod    = $signed({1'b0, lerp_req.frac}) * diff;
      step_in = prod[FRAC_W +: SAMPLE_W];
      mul_valid_in = mul_adv ? lerp_req.valid : mul_valid_ff;
      out_valid_in = out_adv ? mul_valid_ff : out_valid_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (mul_adv) begin
         s0_ff   <= s0;
         step_ff <= step_in;
      end
      if (out_adv) begin
         out_sample_ff <= s0_ff + step_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_sample = out_sample_ff;

endmodule

// File: rtl/core/iwr_checker.sv
// Port-level checker for the interpolated wavetable reader, bound to the top level.
// Depends on iwr_pkg and interpolated_wavetable_reader_macros.svh.
`include "interpolated_wavetable_reader_macros.svh"

module iwr_checker
   import iwr_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [SAMPLE_W-1:0]    rsp_tdata
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       read_accept;
   logic       rsp_accept;
   logic       rsp_stall;

   // Read items accepted but not yet delivered.
   assign read_accept = req_tvalid && req_tready && (opcode_type'(req_tuser) == OP_READ);
   assign rsp_accept  = rsp_tvalid && rsp_tready;
   assign rsp_stall   = rsp_tvalid && !rsp_tready;

   always_comb begin
      pending_in = pending_ff + 3'(read_accept) - 3'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `IWR_ASSERT_ALWAYS_NEXT(a_reset_clears_rsp, reset, !rsp_tvalid, "rsp_tvalid set after reset")
   `IWR_ASSERT_NOW(a_no_invented_rsp, rsp_tvalid, pending_ff != 3'd0, "result without read item")
   `IWR_ASSERT_NOW(a_depth_bound, 1'b1, pending_ff <= 3'd3, "more than three reads in flight")
   `IWR_ASSERT_NOW(a_idle_ready, pending_ff == 3'd0, req_tready, "idle block refuses an item")
   `IWR_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result changed")

endmodule

bind interpolated_wavetable_reader iwr_checker u_checker (.*);
